@@ hw/rtl/mst_pkg.sv @@
package mst_pkg;

  localparam int VERT_W = 6;
  localparam int WGT_W  = 16;
  localparam int VCNT_W = 7;

  localparam logic [VCNT_W-1:0] VCNT_RESET = 7'd64;

  typedef struct packed {
    logic [VERT_W-1:0]       source_vertex;
    logic [VERT_W-1:0]       dest_vertex;
    logic signed [WGT_W-1:0] edge_weight;
    logic                    last_edge;
  } in_beat_t;

  typedef struct packed {
    logic [VERT_W-1:0]       tree_source;
    logic [VERT_W-1:0]       tree_dest;
    logic signed [WGT_W-1:0] tree_weight;
    logic                    edge_valid;
    logic                    dropped_flag;
    logic                    last_result;
  } out_beat_t;

  // One stored edge
  typedef struct packed {
    logic [VERT_W-1:0]       src;
    logic [VERT_W-1:0]       dst;
    logic signed [WGT_W-1:0] w;
  } edge_t;

  // Ascending order: weight, then source, then destination
  function automatic logic edge_less(edge_t a, edge_t b);
    logic res;
    if (a.w != b.w) begin
      res = (a.w < b.w);
    end else if (a.src != b.src) begin
      res = (a.src < b.src);
    end else begin
      res = (a.dst < b.dst);
    end
    return res;
  endfunction

endpackage

@@ hw/rtl/minimum_spanning_tree_engine_unit.sv @@
// Channel | Ports                          | Beat
// input   | in_valid in_ready in_data      | one edge, last_edge starts the run
// result  | out_valid out_ready out_data   | one tree edge, or one empty marker
// config  | cfg_valid cfg_ready cfg_data   | vertex_count, always ready
//
// Load: one edge per cycle into the edge memory.
// Run: insertion sort over the edge memory with one read and one write port,
// each compare step a read state then a compare state; a parent table sweep;
// then per edge two finds with path compression, each parent read then checked.
// in_ready is low from the last edge until the final result enters the output
// register. Output stalls hold the scan. Reset is synchronous, active low.
module minimum_spanning_tree_engine_unit #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  mst_pkg::in_beat_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output mst_pkg::out_beat_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mst_pkg::VCNT_W-1:0]        cfg_data
);
  import mst_pkg::*;

  localparam int ET_W  = $clog2(MAX_EDGES + 1);
  localparam int EA_W  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int PA_W  = $clog2(MAX_VERTICES);
  localparam int KC_W  = $clog2(MAX_VERTICES + 1);
  localparam int WB    = (WEIGHT_BITS < WGT_W) ? WEIGHT_BITS : WGT_W;
  localparam logic [VCNT_W-1:0] MAXV = VCNT_W'(MAX_VERTICES);
  localparam logic [ET_W-1:0]   MAXE = ET_W'(MAX_EDGES);
  localparam logic [KC_W-1:0]   KEND = KC_W'(MAX_VERTICES);

  typedef enum logic [3:0] {
    S_LOAD, S_SKEY, S_SKEYW, S_SRD, S_SCMP, S_INIT, S_EDGE, S_EDGEW,
    S_FRD, S_FCHK, S_CRD, S_CCHK, S_UNION, S_FLUSH
  } state_t;

  state_t            state_r, state_nxt;
  logic [ET_W-1:0]   total_r, total_nxt;
  logic              drop_r, drop_nxt;
  logic [VCNT_W-1:0] vc_r, vc_nxt;
  logic [ET_W-1:0]   i_r, i_nxt;
  logic [ET_W-1:0]   j_r, j_nxt;
  logic [KC_W-1:0]   k_r, k_nxt;
  edge_t             key_r, key_nxt;
  logic [VERT_W-1:0] x_r, x_nxt;
  logic [VERT_W-1:0] fs_r, fs_nxt;
  logic [VERT_W-1:0] root_r, root_nxt;
  logic [VERT_W-1:0] ra_r, ra_nxt;
  logic              phase_r, phase_nxt;
  edge_t             pend_r, pend_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic              out_v_r, out_v_nxt;
  out_beat_t         out_r, out_nxt;

  // edge memory
  edge_t             emem [MAX_EDGES];
  logic              ewe;
  logic [EA_W-1:0]   ewa, era;
  edge_t             ewd, erd_r;

  // parent table
  logic [VERT_W-1:0] pmem [MAX_VERTICES];
  logic              pwe;
  logic [PA_W-1:0]   pwa, pra;
  logic [VERT_W-1:0] pwd, prd_r;

  logic [VCNT_W-1:0] n_eff;
  logic              in_ok, slot_free;
  logic [WGT_W-1:0]  w_ext;
  edge_t             in_edge;

  always_ff @(posedge clk) begin
    if (ewe) begin
      emem[ewa] <= ewd;
    end
    erd_r <= emem[era];
  end

  always_ff @(posedge clk) begin
    if (pwe) begin
      pmem[pwa] <= pwd;
    end
    prd_r <= pmem[pra];
  end

  // Sign-extend the low weight bits
  always_comb begin
    for (int b = 0; b < WGT_W; b++) begin
      w_ext[b] = (b < WB) ? in_data.edge_weight[b] : in_data.edge_weight[WB-1];
    end
  end

  assign n_eff     = (vc_r > MAXV) ? MAXV : vc_r;
  assign in_ok     = ({1'b0, in_data.source_vertex} < n_eff) &&
                     ({1'b0, in_data.dest_vertex} < n_eff) && (total_r < MAXE);
  assign in_edge   = '{src: in_data.source_vertex, dst: in_data.dest_vertex,
                       w: $signed(w_ext)};
  assign slot_free = !out_v_r || out_ready;

  assign in_ready  = (state_r == S_LOAD);
  assign cfg_ready = 1'b1;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt  = state_r;
    total_nxt  = total_r;
    drop_nxt   = drop_r;
    vc_nxt     = vc_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    k_nxt      = k_r;
    key_nxt    = key_r;
    x_nxt      = x_r;
    fs_nxt     = fs_r;
    root_nxt   = root_r;
    ra_nxt     = ra_r;
    phase_nxt  = phase_r;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    out_v_nxt  = out_v_r && !out_ready;
    out_nxt    = out_r;
    ewe        = 1'b0;
    ewa        = total_r[EA_W-1:0];
    ewd        = in_edge;
    era        = i_r[EA_W-1:0];
    pwe        = 1'b0;
    pwa        = PA_W'(k_r);
    pwd        = VERT_W'(k_r);
    pra        = PA_W'(x_r);

    // Register write
    if (cfg_valid) begin
      vc_nxt = cfg_data;
    end

    unique case (state_r)
      // Store incoming edges; flag out-of-range ones or ones past capacity as dropped
      S_LOAD: begin
        if (in_valid) begin
          if (in_ok) begin
            ewe       = 1'b1;
            total_nxt = total_r + 1'b1;
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_data.last_edge) begin
            i_nxt     = ET_W'(1);
            state_nxt = S_SKEY;
          end
        end
      end
      // Insertion sort: fetch key
      S_SKEY: begin
        if (i_r >= total_r) begin
          k_nxt     = '0;
          state_nxt = S_INIT;
        end else begin
          state_nxt = S_SKEYW;
        end
      end
      S_SKEYW: begin
        key_nxt   = erd_r;
        j_nxt     = i_r;
        state_nxt = S_SRD;
      end
      S_SRD: begin
        era = EA_W'(j_r - 1'b1);
        if (j_r == '0) begin
          ewe       = 1'b1;
          ewa       = j_r[EA_W-1:0];
          ewd       = key_r;
          i_nxt     = i_r + 1'b1;
          state_nxt = S_SKEY;
        end else begin
          state_nxt = S_SCMP;
        end
      end
      // Shift the larger neighbor up, or drop the key in place
      S_SCMP: begin
        ewe = 1'b1;
        ewa = j_r[EA_W-1:0];
        if (edge_less(key_r, erd_r)) begin
          ewd       = erd_r;
          j_nxt     = j_r - 1'b1;
          state_nxt = S_SRD;
        end else begin
          ewd       = key_r;
          i_nxt     = i_r + 1'b1;
          state_nxt = S_SKEY;
        end
      end
      // Parent table to identity
      S_INIT: begin
        if (k_r == KEND) begin
          i_nxt     = '0;
          state_nxt = S_EDGE;
        end else begin
          pwe   = 1'b1;
          k_nxt = k_r + 1'b1;
        end
      end
      // Scan sorted edges
      S_EDGE: begin
        if (i_r >= total_r) begin
          state_nxt = S_FLUSH;
        end else begin
          state_nxt = S_EDGEW;
        end
      end
      S_EDGEW: begin
        key_nxt   = erd_r;
        x_nxt     = erd_r.src;
        fs_nxt    = erd_r.src;
        phase_nxt = 1'b0;
        state_nxt = S_FRD;
      end
      // Walk to the root
      S_FRD: begin
        state_nxt = S_FCHK;
      end
      S_FCHK: begin
        if (prd_r == x_r) begin
          root_nxt  = x_r;
          x_nxt     = fs_r;
          state_nxt = S_CRD;
        end else begin
          x_nxt     = prd_r;
          state_nxt = S_FRD;
        end
      end
      // Compress the path onto the root
      S_CRD: begin
        state_nxt = S_CCHK;
      end
      S_CCHK: begin
        if (prd_r != root_r && x_r != root_r) begin
          pwe       = 1'b1;
          pwa       = PA_W'(x_r);
          pwd       = root_r;
          x_nxt     = prd_r;
          state_nxt = S_CRD;
        end else if (!phase_r) begin
          ra_nxt    = root_r;
          x_nxt     = key_r.dst;
          fs_nxt    = key_r.dst;
          phase_nxt = 1'b1;
          state_nxt = S_FRD;
        end else begin
          state_nxt = S_UNION;
        end
      end
      // Merge sets and hand the previous tree edge to the output
      S_UNION: begin
        if (ra_r == root_r) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_EDGE;
        end else if (!pend_v_r || slot_free) begin
          pwe = 1'b1;
          pwa = PA_W'(root_r);
          pwd = ra_r;
          if (pend_v_r) begin
            out_v_nxt = 1'b1;
            out_nxt   = '{tree_source: pend_r.src, tree_dest: pend_r.dst,
                          tree_weight: pend_r.w, edge_valid: 1'b1,
                          dropped_flag: drop_r, last_result: 1'b0};
          end
          pend_nxt   = key_r;
          pend_v_nxt = 1'b1;
          i_nxt      = i_r + 1'b1;
          state_nxt  = S_EDGE;
        end
      end
      // Final result, then ready for the next graph
      S_FLUSH: begin
        if (slot_free) begin
          out_v_nxt = 1'b1;
          if (pend_v_r) begin
            out_nxt = '{tree_source: pend_r.src, tree_dest: pend_r.dst,
                        tree_weight: pend_r.w, edge_valid: 1'b1,
                        dropped_flag: drop_r, last_result: 1'b1};
          end else begin
            out_nxt = '{tree_source: '0, tree_dest: '0, tree_weight: '0,
                        edge_valid: 1'b0, dropped_flag: drop_r, last_result: 1'b1};
          end
          pend_v_nxt = 1'b0;
          total_nxt  = '0;
          drop_nxt   = 1'b0;
          state_nxt  = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_LOAD;
      total_r  <= '0;
      drop_r   <= 1'b0;
      vc_r     <= VCNT_RESET;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      phase_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      total_r  <= total_nxt;
      drop_r   <= drop_nxt;
      vc_r     <= vc_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
      phase_r  <= phase_nxt;
    end
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    k_r    <= k_nxt;
    key_r  <= key_nxt;
    x_r    <= x_nxt;
    fs_r   <= fs_nxt;
    root_r <= root_nxt;
    ra_r   <= ra_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

`ifndef SYNTH
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.edge_valid) |-> out_data.last_result)
    else $error("empty result without last flag");

  a_no_self_loop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.edge_valid) |-> (out_data.tree_source != out_data.tree_dest))
    else $error("self-loop placed in tree");

  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.last_edge) |=> !in_ready)
    else $error("input taken during tree run");
`endif

endmodule
